// ===== design/rwb_pkg.sv =====
// Shared package of the reorder window buffer: default sizes, command and status codes
// and the sequencer state type.
// Used by the top level and the sequencer; it depends on nothing else.
package rwb_pkg;

   localparam int DEPTH_DEF       = 64;
   localparam int SEQ_BITS_DEF    = 16;
   localparam int HANDLE_BITS_DEF = 16;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;

   // Command codes carried on the request side.
   localparam logic [CMD_W-1:0] CMD_ACCEPT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GET     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

   // Status codes returned with every response.
   localparam logic [STATUS_W-1:0] STATUS_OK            = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_WINDOW = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_OCCUPIED      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTHING_READY = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_CAUGHT_UP = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_CHECK,
      ST_SCAN,
      ST_SCAN_CHK,
      ST_TAKE,
      ST_RESP
   } rwb_state_type;

endpackage

// ===== design/reorder_window_buffer.sv =====
// Reorder window buffer, top level. Path from request beat to response in the output
// register: advance, the unused code, an empty get and an out-of-window accept pass EXEC
// only; a delivering get adds TAKE and an occupied accept adds CHECK; a stored accept adds
// CHECK and the read-and-test loop of the in-order scan (SCAN, SCAN_CHK). One request at a
// time; the next is taken in the cycle after its response enters the output register.
// Reset is synchronous, active high, and clears every slot of the store in turn (tready low).
module reorder_window_buffer #(
   parameter int DEPTH       = rwb_pkg::DEPTH_DEF,
   parameter int SEQ_BITS    = rwb_pkg::SEQ_BITS_DEF,
   parameter int HANDLE_BITS = rwb_pkg::HANDLE_BITS_DEF,
   localparam int REQ_W = ((SEQ_BITS + HANDLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((HANDLE_BITS + 2 * SEQ_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_W-1:0]              req_tdata,  // seq, msg_handle, zero fill
   input  logic [rwb_pkg::CMD_W-1:0]     req_tuser,  // cmd
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_W-1:0]              rsp_tdata,  // msg_out, in_order_seq, oldest_seq, fill
   output logic [rwb_pkg::STATUS_W-1:0]  rsp_tuser   // status
);

   localparam int DATA_W = HANDLE_BITS + 2 * SEQ_BITS;

   logic                         res_valid;
   logic                         res_ready;
   logic [HANDLE_BITS-1:0]       res_msg;
   logic [rwb_pkg::STATUS_W-1:0] res_status;
   logic [SEQ_BITS-1:0]          res_in_order;
   logic [SEQ_BITS-1:0]          res_oldest;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]            rsp_data_ff, rsp_data_in;
   logic [rwb_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // The sequencer owns the window pointers and the slot store.
   rwb_ctrl #(
      .DEPTH       (DEPTH),
      .SEQ_BITS    (SEQ_BITS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_cmd      (req_tuser),
      .req_seq      (req_tdata[SEQ_BITS-1:0]),
      .req_handle   (req_tdata[SEQ_BITS+HANDLE_BITS-1:SEQ_BITS]),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res_msg      (res_msg),
      .res_status   (res_status),
      .res_in_order (res_in_order),
      .res_oldest   (res_oldest)
   );

   // Output register: free when empty or when its beat is being taken this cycle.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
      end
      if (res_valid && res_ready) begin
         rsp_data_in   = {res_oldest, res_in_order, res_msg};
         rsp_status_in = res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== design/rwb_slot_ram.sv =====
// Slot store of the reorder window: one write port and one read port with registered
// read data. Each word holds the full flag above the message handle.
// Depends on nothing but its parameters.
module rwb_slot_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 17
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rwb_win_unit.sv =====
// Shared window arithmetic of the reorder window buffer: distance from the oldest
// pointer, the in-window compare and the modular increment of one operand.
// Depends on nothing but its parameters.
module rwb_win_unit #(
   parameter int DEPTH    = 64,
   parameter int SEQ_BITS = 16
) (
   input  logic [SEQ_BITS-1:0] opnd,
   input  logic [SEQ_BITS-1:0] base,
   output logic                in_win,
   output logic [SEQ_BITS-1:0] opnd_inc
);

   localparam logic [SEQ_BITS:0] DEPTH_X = (SEQ_BITS + 1)'(DEPTH);

   logic [SEQ_BITS-1:0] gap;

   // Sequence arithmetic wraps at the width of the operands.
   assign gap      = opnd - base;
   assign in_win   = {1'b0, gap} < DEPTH_X;
   assign opnd_inc = opnd + SEQ_BITS'(1);

endmodule

// ===== design/rwb_ctrl.sv =====
// Sequencer of the reorder window buffer: holds the window pointers, drives the slot
// store and steps the in-order pointer through the shared window unit.
// Depends on rwb_pkg, rwb_slot_ram and rwb_win_unit.
module rwb_ctrl #(
   parameter int DEPTH       = rwb_pkg::DEPTH_DEF,
   parameter int SEQ_BITS    = rwb_pkg::SEQ_BITS_DEF,
   parameter int HANDLE_BITS = rwb_pkg::HANDLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rwb_pkg::CMD_W-1:0]     req_cmd,
   input  logic [SEQ_BITS-1:0]           req_seq,
   input  logic [HANDLE_BITS-1:0]        req_handle,
   output logic                          res_valid,
   input  logic                          res_ready,
   output logic [HANDLE_BITS-1:0]        res_msg,
   output logic [rwb_pkg::STATUS_W-1:0]  res_status,
   output logic [SEQ_BITS-1:0]           res_in_order,
   output logic [SEQ_BITS-1:0]           res_oldest
);

   localparam int SLOT_W = $clog2(DEPTH);
   localparam int WORD_W = HANDLE_BITS + 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

   rwb_pkg::rwb_state_type state_ff, state_in;

   logic [rwb_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [SEQ_BITS-1:0]          seq_ff, seq_in;
   logic [HANDLE_BITS-1:0]       handle_ff, handle_in;
   logic [SEQ_BITS-1:0]          in_order_ff, in_order_in;
   logic [SEQ_BITS-1:0]          oldest_ff, oldest_in;
   logic [rwb_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [HANDLE_BITS-1:0]       msg_ff, msg_in;
   logic [SLOT_W-1:0]            clr_cnt_ff, clr_cnt_in;

   logic                    wr_en;
   logic [SLOT_W-1:0]       wr_addr;
   logic [WORD_W-1:0]       wr_data;
   logic [SLOT_W-1:0]       rd_addr;
   logic [WORD_W-1:0]       rd_data;
   logic                    rd_full;
   logic [HANDLE_BITS-1:0]  rd_handle;

   logic [SEQ_BITS-1:0]     opnd;
   logic                    in_win;
   logic [SEQ_BITS-1:0]     opnd_inc;
   logic                    caught_up;

   assign rd_full   = rd_data[WORD_W-1];
   assign rd_handle = rd_data[HANDLE_BITS-1:0];
   assign caught_up = (in_order_ff == oldest_ff);

   rwb_slot_ram #(
      .DEPTH (DEPTH),
      .WIDTH (WORD_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rwb_win_unit #(
      .DEPTH    (DEPTH),
      .SEQ_BITS (SEQ_BITS)
   ) u_win_unit (
      .opnd     (opnd),
      .base     (oldest_ff),
      .in_win   (in_win),
      .opnd_inc (opnd_inc)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rwb_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == LAST_SLOT) begin
               state_in = rwb_pkg::ST_IDLE;
            end
         end
         rwb_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = rwb_pkg::ST_EXEC;
            end
         end
         rwb_pkg::ST_EXEC: begin
            if (cmd_ff == rwb_pkg::CMD_ACCEPT) begin
               state_in = in_win ? rwb_pkg::ST_CHECK : rwb_pkg::ST_RESP;
            end else if (cmd_ff == rwb_pkg::CMD_GET) begin
               state_in = caught_up ? rwb_pkg::ST_RESP : rwb_pkg::ST_TAKE;
            end else begin
               state_in = rwb_pkg::ST_RESP;
            end
         end
         rwb_pkg::ST_CHECK: begin
            state_in = rd_full ? rwb_pkg::ST_RESP : rwb_pkg::ST_SCAN;
         end
         rwb_pkg::ST_SCAN: begin
            state_in = in_win ? rwb_pkg::ST_SCAN_CHK : rwb_pkg::ST_RESP;
         end
         rwb_pkg::ST_SCAN_CHK: begin
            state_in = rd_full ? rwb_pkg::ST_SCAN : rwb_pkg::ST_RESP;
         end
         rwb_pkg::ST_TAKE: begin
            state_in = rwb_pkg::ST_RESP;
         end
         rwb_pkg::ST_RESP: begin
            if (res_ready) begin
               state_in = rwb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rwb_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs: handshakes, operand of the window unit and slot store ports.
   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      opnd      = in_order_ff;
      rd_addr   = in_order_ff[SLOT_W-1:0];
      wr_en     = 1'b0;
      wr_addr   = clr_cnt_ff;
      wr_data   = '0;
      unique case (state_ff)
         rwb_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
         end
         rwb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         rwb_pkg::ST_EXEC: begin
            if (cmd_ff == rwb_pkg::CMD_ACCEPT) begin
               opnd    = seq_ff;
               rd_addr = seq_ff[SLOT_W-1:0];
            end else begin
               rd_addr = oldest_ff[SLOT_W-1:0];
            end
         end
         rwb_pkg::ST_CHECK: begin
            wr_en   = !rd_full;
            wr_addr = seq_ff[SLOT_W-1:0];
            wr_data = {1'b1, handle_ff};
         end
         rwb_pkg::ST_SCAN, rwb_pkg::ST_SCAN_CHK: begin
            opnd    = in_order_ff;
         end
         rwb_pkg::ST_TAKE: begin
            opnd    = oldest_ff;
            wr_en   = 1'b1;
            wr_addr = oldest_ff[SLOT_W-1:0];
            wr_data = {1'b0, rd_handle};
         end
         rwb_pkg::ST_RESP: begin
            res_valid = 1'b1;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // Register updates.
   always_comb begin
      cmd_in      = cmd_ff;
      seq_in      = seq_ff;
      handle_in   = handle_ff;
      in_order_in = in_order_ff;
      oldest_in   = oldest_ff;
      status_in   = status_ff;
      msg_in      = msg_ff;
      clr_cnt_in  = clr_cnt_ff;
      case (state_ff)
         rwb_pkg::ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + SLOT_W'(1);
         end
         rwb_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               seq_in    = req_seq;
               handle_in = req_handle;
               status_in = rwb_pkg::STATUS_OK;
               msg_in    = '0;
            end
         end
         rwb_pkg::ST_EXEC: begin
            case (cmd_ff)
               rwb_pkg::CMD_ACCEPT: begin
                  if (!in_win) begin
                     status_in = rwb_pkg::STATUS_OUT_OF_WINDOW;
                  end
               end
               rwb_pkg::CMD_GET: begin
                  if (caught_up) begin
                     status_in = rwb_pkg::STATUS_NOTHING_READY;
                  end
               end
               rwb_pkg::CMD_ADVANCE: begin
                  // When both pointers are equal, one increment serves both.
                  if (!caught_up) begin
                     status_in = rwb_pkg::STATUS_NOT_CAUGHT_UP;
                  end else begin
                     in_order_in = opnd_inc;
                     oldest_in   = opnd_inc;
                  end
               end
               default: begin
                  status_in = rwb_pkg::STATUS_OK;
               end
            endcase
         end
         rwb_pkg::ST_CHECK: begin
            if (rd_full) begin
               status_in = rwb_pkg::STATUS_OCCUPIED;
            end
         end
         rwb_pkg::ST_SCAN_CHK: begin
            if (rd_full) begin
               in_order_in = opnd_inc;
            end
         end
         rwb_pkg::ST_TAKE: begin
            msg_in    = rd_handle;
            oldest_in = opnd_inc;
         end
         default: begin
            clr_cnt_in = clr_cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= rwb_pkg::ST_CLEAR;
         in_order_ff <= '0;
         oldest_ff   <= '0;
         clr_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         in_order_ff <= in_order_in;
         oldest_ff   <= oldest_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      seq_ff    <= seq_in;
      handle_ff <= handle_in;
      status_ff <= status_in;
      msg_ff    <= msg_in;
   end

   assign res_msg      = msg_ff;
   assign res_status   = status_ff;
   assign res_in_order = in_order_ff;
   assign res_oldest   = oldest_ff;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for reorder_window_buffer: a window predictor class and the tasks
// that drive the request stream and take in the response stream.
// Depends on rwb_pkg and the reorder_window_buffer RTL only.
module tb;
   import rwb_pkg::*;

   localparam int SLOTS    = DEPTH_DEF;
   localparam int SEQ_W    = SEQ_BITS_DEF;
   localparam int HANDLE_W = HANDLE_BITS_DEF;
   localparam int REQ_W    = ((SEQ_W + HANDLE_W + 7) / 8) * 8;
   localparam int RSP_W    = ((HANDLE_W + 2 * SEQ_W + 7) / 8) * 8;

   // The fourth command code is not named by the package; the block must treat it as a no-op.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [HANDLE_W-1:0] msg;
      logic [STATUS_W-1:0] status;
      logic [SEQ_W-1:0]    in_order_seq;
      logic [SEQ_W-1:0]    oldest_seq;
   } window_result_type;

   // Tracks the window as the block should hold it and keeps the results still owed.
   class window_tracker;
      bit                  slot_full [SLOTS];
      logic [HANDLE_W-1:0] slot_handle [SLOTS];
      logic [SEQ_W-1:0]    oldest;
      logic [SEQ_W-1:0]    in_order;
      window_result_type   owed_results[$];
      int                  errors;

      function new();
         foreach (slot_full[i]) slot_full[i] = 1'b0;
         oldest   = '0;
         in_order = '0;
         errors   = 0;
      endfunction

      function bit in_window(logic [SEQ_W-1:0] s);
         logic [SEQ_W-1:0] gap;
         gap = s - oldest;
         return gap < SLOTS;
      endfunction

      // Applies one accepted request beat to the window and queues the response it owes.
      function void note_request(logic [CMD_W-1:0] cmd, logic [SEQ_W-1:0] seq,
                                 logic [HANDLE_W-1:0] handle);
         window_result_type r;
         int                steps;
         int                slot;
         r.msg    = '0;
         r.status = STATUS_OK;
         slot     = int'(seq) % SLOTS;
         case (cmd)
            CMD_ACCEPT: begin
               if (!in_window(seq)) begin
                  r.status = STATUS_OUT_OF_WINDOW;
               end else if (slot_full[slot]) begin
                  r.status = STATUS_OCCUPIED;
               end else begin
                  slot_full[slot]   = 1'b1;
                  slot_handle[slot] = handle;
                  steps = 0;
                  while (steps < SLOTS && slot_full[int'(in_order) % SLOTS] &&
                         in_window(in_order)) begin
                     in_order = in_order + 1'b1;
                     steps++;
                  end
               end
            end
            CMD_GET: begin
               if (in_order == oldest) begin
                  r.status = STATUS_NOTHING_READY;
               end else begin
                  r.msg = slot_handle[int'(oldest) % SLOTS];
                  slot_full[int'(oldest) % SLOTS] = 1'b0;
                  oldest = oldest + 1'b1;
               end
            end
            CMD_ADVANCE: begin
               if (in_order != oldest) begin
                  r.status = STATUS_NOT_CAUGHT_UP;
               end else begin
                  oldest   = oldest + 1'b1;
                  in_order = in_order + 1'b1;
               end
            end
            default: begin
            end
         endcase
         r.in_order_seq = in_order;
         r.oldest_seq   = oldest;
         owed_results.push_back(r);
      endfunction

      function void check_response(logic [HANDLE_W-1:0] msg, logic [STATUS_W-1:0] status,
                                   logic [SEQ_W-1:0] ioseq, logic [SEQ_W-1:0] oseq);
         window_result_type e;
         if (owed_results.size() == 0) begin
            $error("response beat arrived with nothing owed");
            errors++;
            return;
         end
         e = owed_results.pop_front();
         if (msg !== e.msg) begin
            $error("msg_out: expected %h, got %h", e.msg, msg);
            errors++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
         end
         if (ioseq !== e.in_order_seq) begin
            $error("in_order_seq: expected %h, got %h", e.in_order_seq, ioseq);
            errors++;
         end
         if (oseq !== e.oldest_seq) begin
            $error("oldest_seq: expected %h, got %h", e.oldest_seq, oseq);
            errors++;
         end
      endfunction

      function int owed();
         return owed_results.size();
      endfunction
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata  = '0;  // seq, msg_handle
   logic [CMD_W-1:0]    req_tuser  = CMD_ACCEPT;  // cmd
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;  // msg_out, in_order_seq, oldest_seq
   logic [STATUS_W-1:0] rsp_tuser;  // status

   window_tracker window;

   // Percentages of cycles in which each side holds back, and a one-off receiver hold-off
   // that the stimulus process hands to the response process.
   int send_idle_pct    = 0;
   int recv_idle_pct    = 0;
   int hold_off_request = 0;

   reorder_window_buffer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // Offers one request beat, after a random number of idle cycles, and holds it until the
   // block takes it. The valid stays high on return so that back-to-back beats need no
   // extra cycle; whoever comes next either drives a new beat or lowers it.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] seq,
                            input logic [HANDLE_W-1:0] handle);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_W'({handle, seq});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      window.note_request(cmd, seq, handle);
   endtask

   // Stops offering and waits until every owed response beat has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (window.owed() > 0) @(posedge clock);
   endtask

   // One random request. Most accepts land inside the window, a good share of them exactly
   // on the next number expected in order, so that in-order runs form and the window fills
   // up; the rest are out-of-window noise. Gets and advances are issued regardless of state,
   // so refused ones come up naturally.
   task automatic send_random();
      int unsigned      pick;
      logic [SEQ_W-1:0] seq;
      pick = $urandom_range(0, 99);
      seq  = window.oldest + SEQ_W'($urandom_range(0, SLOTS - 1));
      if (pick < 18) begin
         seq = window.in_order;
      end else if (pick >= 45 && pick < 50) begin
         seq = window.oldest + SEQ_W'($urandom_range(SLOTS, 65535));
      end
      if (pick < 50) begin
         send_item(CMD_ACCEPT, seq, HANDLE_W'($urandom));
      end else if (pick < 80) begin
         send_item(CMD_GET, SEQ_W'($urandom), HANDLE_W'($urandom));
      end else if (pick < 97) begin
         send_item(CMD_ADVANCE, SEQ_W'($urandom), HANDLE_W'($urandom));
      end else begin
         send_item(CMD_UNUSED, SEQ_W'($urandom), HANDLE_W'($urandom));
      end
   endtask

   // Response side: checks every beat taken, then decides the ready for the next cycle.
   // A hold-off request keeps ready low for a counted stretch of cycles.
   initial begin : response_side
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            window.check_response(rsp_tdata[HANDLE_W-1:0], rsp_tuser,
                                  rsp_tdata[HANDLE_W+SEQ_W-1:HANDLE_W],
                                  rsp_tdata[HANDLE_W+2*SEQ_W-1:HANDLE_W+SEQ_W]);
         end
         if (hold_off_request > 0) begin
            hold = hold_off_request;
            hold_off_request = 0;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin : stimulus
      window = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: refused commands of every kind, field extremes, the window edges,
      // an advance that passes over a filled slot without rescanning, and the unused code.
      send_item(CMD_GET, 16'h0000, 16'h0000);       // nothing deliverable on an empty window
      send_item(CMD_ADVANCE, 16'hFFFF, 16'hFFFF);   // caught up, so both pointers step
      send_item(CMD_ACCEPT, 16'd1, 16'hFFFF);       // in order, run moves on by one
      send_item(CMD_ACCEPT, 16'd1, 16'h1234);       // same slot again: occupied
      send_item(CMD_ACCEPT, 16'd0, 16'h0001);       // just behind the window
      send_item(CMD_ACCEPT, 16'd65, 16'h0002);      // one past the window end
      send_item(CMD_ACCEPT, 16'hFFFF, 16'h0003);    // top sequence number, behind the window
      send_item(CMD_ACCEPT, 16'd64, 16'h0000);      // last slot of the window
      send_item(CMD_ADVANCE, 16'd0, 16'd0);         // in-order pointer is ahead: refused
      send_item(CMD_GET, 16'd0, 16'd0);             // hands back the first handle
      send_item(CMD_GET, 16'd0, 16'd0);             // caught up again: nothing ready
      send_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF);    // no-op, plain ok
      send_item(CMD_ADVANCE, 16'd0, 16'd0);         // skip a missing number
      send_item(CMD_ACCEPT, 16'd4, 16'hA5A5);       // out of order, leaves a hole at 3
      send_item(CMD_ADVANCE, 16'd0, 16'd0);         // skip 3; slot 4 is full but not scanned
      send_item(CMD_GET, 16'd0, 16'd0);             // still nothing ready
      send_item(CMD_ACCEPT, 16'd5, 16'h5A5A);       // scan now passes over 4 and 5
      send_item(CMD_GET, 16'd0, 16'd0);
      send_item(CMD_GET, 16'd0, 16'd0);
      drain();

      // Sender busy, receiver mostly stalled. A long hold-off at the start lets the block
      // fill up and push back on the request side while beats keep being offered.
      send_idle_pct    = 38;
      recv_idle_pct    = 86;
      hold_off_request = 300;
      repeat (430) send_random();
      drain();

      // Sender mostly idle, receiver mostly ready, with a pause until everything is back.
      send_idle_pct = 86;
      recv_idle_pct = 38;
      repeat (215) send_random();
      drain();
      repeat (215) send_random();
      drain();

      // Last phase without idling on either side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (440) send_random();
      drain();

      // A stored accept runs the in-order scan; allow for that and more for stray beats.
      repeat (4 * SLOTS) @(posedge clock);
      if (window.errors == 0 && window.owed() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Guard against a hung handshake: far beyond the slowest correct run.
   initial begin : watchdog
      #40_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule

// ===== files.f =====
design/rwb_pkg.sv
design/rwb_slot_ram.sv
design/rwb_win_unit.sv
design/rwb_ctrl.sv
design/reorder_window_buffer.sv
tb/sv/tb.sv
